>>> rtl/core/scfr_pkg.sv
// ----------------------------------------------------------------------------
// scfr_pkg
// Types, symbol codes and the CRC-16 byte step shared by the SLIP frame
// receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

	localparam int DEF_MAX_PAYLOAD    = 512;
	localparam int DEF_FRAME_CAPACITY = 520;

	localparam int HDR_BYTES     = 6;
	localparam int MIN_FRAME     = 8;
	localparam int INDEX_W       = 10;
	localparam int LENGTH_W      = 10;

	localparam logic [7:0] SYM_END       = 8'hC0;
	localparam logic [7:0] SYM_ESC       = 8'hDB;
	localparam logic [7:0] SYM_ESC_END   = 8'hDC;
	localparam logic [7:0] SYM_ESC_ESC   = 8'hDD;
	localparam logic [7:0] FRAME_VERSION = 8'h01;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic ACT_RX   = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [7:0]           rx_byte;
		logic [INDEX_W-1:0]   read_index;
	} item_t;

	typedef struct packed {
		logic                 result_kind;
		logic [7:0]           opcode;
		logic [7:0]           sequence_res;
		logic [7:0]           channel;
		logic [LENGTH_W-1:0]  payload_length;
		logic [7:0]           read_data;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> rtl/core/slip_crc_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// slip_crc_frame_receiver_core
// SLIP deframer with frame buffer, header check and running CRC-16.
// ----------------------------------------------------------------------------
// Use:
// The item channel carries one word per cycle when not stalled: either a raw
// serial byte to decode, or a read of one frame buffer position. The result
// channel returns a word for every buffer read and for every END that closes
// a valid frame; other bytes and rejected frames give no word.
// Throughput is one item per cycle while item_stall is low. The CRC runs two
// bytes behind the decoder and the last two bytes and the header sit in
// registers, so END is checked as it is accepted; the buffer has one write
// port and one registered read port.
// An accepted item passes through stage one and then the output register
// before result_valid rises.
// Reset clears the decoder state and both result stages; the buffer is not
// cleared and needs no sweep, so items are taken from the first cycle.
// When result_stall is held, one word waits in the output register and a
// second in stage one; item_stall then rises until the output drains.
// ----------------------------------------------------------------------------
module slip_crc_frame_receiver_core
	import scfr_pkg::*;
#(
	parameter int MAX_PAYLOAD    = DEF_MAX_PAYLOAD,
	parameter int FRAME_CAPACITY = DEF_FRAME_CAPACITY
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CW = $clog2(FRAME_CAPACITY + 1);
	localparam int AW = $clog2(FRAME_CAPACITY);
	localparam int HW = $clog2(HDR_BYTES);

	logic [CW-1:0] count_q;
	logic          esc_q;
	logic          ovf_q;
	logic          started_q;
	logic [15:0]   crc_q;
	logic [7:0]    prev1_q;
	logic [7:0]    prev2_q;
	logic [7:0]    hdr_q [HDR_BYTES];

	logic [7:0]    mem [FRAME_CAPACITY];

	logic                valid_s1;
	logic                kind_s1;
	logic [7:0]          opcode_s1;
	logic [7:0]          seq_s1;
	logic [7:0]          chan_s1;
	logic [LENGTH_W-1:0] plen_s1;
	logic                rd_ok_s1;
	logic [7:0]          rd_data_s1;

	logic    valid_s2;
	result_t result_s2;

	logic          item_acc;
	logic          s1_move;
	logic          is_read;
	logic          is_end;
	logic          store;
	logic [7:0]    dec_byte;
	logic          esc_next;
	logic          has_room;
	logic          rd_in_range;
	logic [AW-1:0] rd_addr;
	logic [15:0]   plen;
	logic          frame_ok;
	logic          emit;

	assign item_acc   = item_valid && !item_stall;
	assign s1_move    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !s1_move;

	assign is_read = (item.action == ACT_READ);
	assign is_end  = !is_read && (item.rx_byte == SYM_END);

	always_comb begin
		store    = 1'b0;
		dec_byte = item.rx_byte;
		esc_next = esc_q;
		if (!is_read && !is_end) begin
			if (item.rx_byte == SYM_ESC) begin
				esc_next = 1'b1;
			end else if (esc_q) begin
				esc_next = 1'b0;
				if (item.rx_byte == SYM_ESC_END) begin
					store    = 1'b1;
					dec_byte = SYM_END;
				end else if (item.rx_byte == SYM_ESC_ESC) begin
					store    = 1'b1;
					dec_byte = SYM_ESC;
				end
			end else begin
				store = 1'b1;
			end
		end
	end

	assign has_room    = 32'(count_q) < FRAME_CAPACITY;
	assign rd_in_range = 32'(item.read_index) < FRAME_CAPACITY;
	assign rd_addr     = AW'(item.read_index);

	assign plen     = {hdr_q[5], hdr_q[4]};
	assign frame_ok = !ovf_q
		&& (32'(count_q) >= MIN_FRAME)
		&& (hdr_q[0] == FRAME_VERSION)
		&& (32'(plen) <= MAX_PAYLOAD)
		&& (32'(plen) + MIN_FRAME == 32'(count_q))
		&& ({prev1_q, prev2_q} == crc_q);
	assign emit = is_end && started_q && (count_q != '0) && frame_ok;

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			esc_q     <= 1'b0;
			ovf_q     <= 1'b0;
			started_q <= 1'b0;
			crc_q     <= CRC_INIT;
		end else if (item_acc && !is_read) begin
			started_q <= 1'b1;
			if (is_end) begin
				count_q <= '0;
				esc_q   <= 1'b0;
				ovf_q   <= 1'b0;
				crc_q   <= CRC_INIT;
			end else begin
				esc_q <= esc_next;
				if (store) begin
					if (has_room) begin
						count_q <= count_q + 1'b1;
						if (count_q >= CW'(2)) begin
							crc_q <= crc16_byte(crc_q, prev2_q);
						end
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
		end
	end

	// last two bytes and header
	always_ff @(posedge clk) begin
		if (item_acc && store && has_room) begin
			prev1_q <= dec_byte;
			prev2_q <= prev1_q;
			if (32'(count_q) < HDR_BYTES) begin
				hdr_q[HW'(count_q)] <= dec_byte;
			end
		end
	end

	// frame buffer
	always_ff @(posedge clk) begin
		if (item_acc && store && has_room) begin
			mem[AW'(count_q)] <= dec_byte;
		end
		if (item_acc && is_read && rd_in_range) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= is_read || emit;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			kind_s1   <= is_read ? KIND_READ : KIND_FRAME;
			rd_ok_s1  <= is_read && rd_in_range;
			opcode_s1 <= emit ? hdr_q[1] : 8'h00;
			seq_s1    <= emit ? hdr_q[2] : 8'h00;
			chan_s1   <= emit ? hdr_q[3] : 8'h00;
			plen_s1   <= emit ? plen[LENGTH_W-1:0] : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			result_s2.result_kind    <= kind_s1;
			result_s2.opcode         <= opcode_s1;
			result_s2.sequence_res   <= seq_s1;
			result_s2.channel        <= chan_s1;
			result_s2.payload_length <= plen_s1;
			result_s2.read_data      <= rd_ok_s1 ? rd_data_s1 : 8'h00;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && result_stall |=> valid_s1 && $stable(kind_s1))
		else $error("stage one word lost while output stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= FRAME_CAPACITY)
		else $error("byte count beyond capacity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && is_end |=> count_q == '0 && !esc_q && !ovf_q && crc_q == CRC_INIT)
		else $error("decoder not cleared after END");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_FRAME
			|-> 32'(result.payload_length) <= MAX_PAYLOAD && result.read_data == 8'h00)
		else $error("frame result with bad length or read data");
`endif

endmodule
